// File: rtl/scf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the I2C slave command framer
// Buffer geometry, event and result codes, queue sizing.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int BYTE_W    = 8;
    localparam int BUF_DEPTH = 32;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    // receive index saturates at BUF_DEPTH, so it needs one more code
    localparam int IDX_W     = $clog2(BUF_DEPTH + 1);
    localparam int READ_BIT  = 7;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // event code on the input tuser
    typedef enum logic [1:0] {
        OP_ADDR = 2'd0,
        OP_RX   = 2'd1,
        OP_TX   = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // classified event held in the queue
    typedef enum logic [1:0] {
        EV_ADDR,
        EV_RX,
        EV_TX
    } t_evt_kind;

    typedef struct packed {
        t_evt_kind         kind;
        logic [BYTE_W-1:0] data;
    } t_evt;

    // result kind on the output tuser
    typedef enum logic [1:0] {
        OK_SEND  = 2'd0,
        OK_DONE  = 2'd1,
        OK_QUEUE = 2'd2
    } t_out_kind;

    typedef enum logic {
        ENG_IDLE,
        ENG_RUN
    } t_eng_state;

endpackage
`default_nettype wire

// File: rtl/scf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_front: event intake
// Accepts input words, drops the unused event code, and queues the rest
// for the engine.
// ----------------------------------------------------------------------------
module scf_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [scf_pkg::BYTE_W-1:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]                 i_s_tuser,   // [1:0] op
    output logic                            o_evt_valid,
    input  wire logic                       i_evt_ready,
    output scf_pkg::t_evt                   o_evt
);

    scf_pkg::t_evt                r_q [scf_pkg::Q_DEPTH];
    logic [scf_pkg::Q_PTR_W-1:0]  r_wptr, n_wptr;
    logic [scf_pkg::Q_PTR_W-1:0]  r_rptr, n_rptr;
    logic [scf_pkg::Q_CNT_W-1:0]  r_cnt,  n_cnt;

    logic          accept;
    logic          push;
    logic          pop;
    scf_pkg::t_evt evt_in;
    logic          evt_keep;

    always_comb begin
        evt_in.data = i_s_tdata;
        evt_in.kind = scf_pkg::EV_ADDR;
        evt_keep    = 1'b1;
        unique case (scf_pkg::t_op'(i_s_tuser))
            scf_pkg::OP_ADDR: evt_in.kind = scf_pkg::EV_ADDR;
            scf_pkg::OP_RX:   evt_in.kind = scf_pkg::EV_RX;
            scf_pkg::OP_TX:   evt_in.kind = scf_pkg::EV_TX;
            default:          evt_keep    = 1'b0;   // unused code: no effect
        endcase
    end

    assign o_s_tready  = (r_cnt != scf_pkg::Q_CNT_W'(scf_pkg::Q_DEPTH));
    assign accept      = i_s_tvalid && o_s_tready;
    assign push        = accept && evt_keep;
    assign o_evt_valid = (r_cnt != '0);
    assign o_evt       = r_q[r_rptr];
    assign pop         = o_evt_valid && i_evt_ready;

    always_comb begin
        n_wptr = push ? r_wptr + scf_pkg::Q_PTR_W'(1) : r_wptr;
        n_rptr = pop  ? r_rptr + scf_pkg::Q_PTR_W'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + scf_pkg::Q_CNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - scf_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= evt_in;
        end
    end

endmodule
`default_nettype wire

// File: rtl/scf_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_engine: frame state and result sequencer
// Applies one queued event at a time to the receive/transmit buffers and
// plays out completed frames into the output register, one word per cycle while the receiver takes each word.
// ----------------------------------------------------------------------------
module scf_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_evt_valid,
    output logic                            o_evt_ready,
    input  wire scf_pkg::t_evt              i_evt,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [scf_pkg::BYTE_W-1:0]      o_m_tdata,   // [7:0] data
    output logic [1:0]                      o_m_tuser,   // [1:0] kind
    output logic                            o_m_tlast
);

    localparam int ADDR_W = scf_pkg::ADDR_W;
    localparam int IDX_W  = scf_pkg::IDX_W;
    localparam int BW     = scf_pkg::BYTE_W;
    localparam int DEPTH  = scf_pkg::BUF_DEPTH;

    logic [BW-1:0]     r_rx_store [DEPTH];
    logic [BW-1:0]     r_tx_store [DEPTH];

    logic [IDX_W-1:0]  r_rx_idx, n_rx_idx;
    logic [ADDR_W-1:0] r_rx_cnt, n_rx_cnt;
    logic [ADDR_W-1:0] r_tx_idx, n_tx_idx;
    logic [ADDR_W-1:0] r_tx_cnt, n_tx_cnt;
    logic [BW-1:0]     r_cmd,    n_cmd;
    logic [ADDR_W-1:0] r_k,      n_k;

    scf_pkg::t_eng_state r_state, n_state;

    logic              r_out_valid, n_out_valid;
    scf_pkg::t_out_kind r_out_kind, n_out_kind;
    logic [BW-1:0]     r_out_data, n_out_data;
    logic              r_out_last, n_out_last;

    logic              out_free;
    logic              rx_in_range;
    logic              rx_at_len;
    logic              snap;
    logic [ADDR_W-1:0] rd_len;
    logic [ADDR_W-1:0] wr_len;
    logic [ADDR_W-1:0] cnt_sel;
    logic              frame_done;
    logic [BW-1:0]     tx_first;
    logic [ADDR_W-1:0] run_addr;

    logic              rx_wr_en;
    logic              fix_one;
    logic              copy_en;

    assign out_free    = !r_out_valid || i_m_tready;
    assign rx_in_range = (r_rx_idx < IDX_W'(DEPTH));
    assign rx_at_len   = (r_rx_idx == IDX_W'(1));
    assign snap        = rx_at_len && r_cmd[scf_pkg::READ_BIT];

    // length clamps: reads to DEPTH-1 bytes, writes to DEPTH-2 bytes
    assign rd_len = (i_evt.data > BW'(DEPTH - 1)) ? ADDR_W'(DEPTH - 1)
                                                   : i_evt.data[ADDR_W-1:0];
    assign wr_len = (i_evt.data > BW'(DEPTH - 2)) ? ADDR_W'(DEPTH - 2)
                                                   : i_evt.data[ADDR_W-1:0];

    always_comb begin
        cnt_sel = r_rx_cnt;
        if (rx_at_len) begin
            cnt_sel = r_cmd[scf_pkg::READ_BIT] ? '0 : wr_len;
        end
    end

    assign frame_done = rx_in_range &&
                        (IDX_W'(cnt_sel) + IDX_W'(2) == r_rx_idx + IDX_W'(1));

    // first transmit byte as it stands after the snapshot copy
    assign tx_first = (rd_len != '0) ? r_rx_store[1] : r_tx_store[0];
    assign run_addr = r_k + ADDR_W'(1);

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rx_idx    = r_rx_idx;
        n_rx_cnt    = r_rx_cnt;
        n_tx_idx    = r_tx_idx;
        n_tx_cnt    = r_tx_cnt;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_evt_ready = 1'b0;
        rx_wr_en    = 1'b0;
        fix_one     = 1'b0;
        copy_en     = 1'b0;

        unique case (r_state)
            scf_pkg::ENG_IDLE: begin
                o_evt_ready = out_free;
                if (i_evt_valid && out_free) begin
                    unique case (i_evt.kind)
                        scf_pkg::EV_ADDR: begin
                            n_rx_idx = '0;
                        end
                        scf_pkg::EV_TX: begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            if (r_tx_idx < r_tx_cnt) begin
                                n_out_kind = scf_pkg::OK_SEND;
                                n_out_data = r_tx_store[r_tx_idx];
                                n_tx_idx   = r_tx_idx + ADDR_W'(1);
                            end else begin
                                n_out_kind = scf_pkg::OK_DONE;
                                n_out_data = '0;
                            end
                        end
                        scf_pkg::EV_RX: begin
                            rx_wr_en = rx_in_range;
                            n_rx_cnt = cnt_sel;
                            if (r_rx_idx == '0) begin
                                n_cmd = i_evt.data;
                            end
                            if (snap) begin
                                copy_en     = 1'b1;
                                n_tx_cnt    = rd_len;
                                n_tx_idx    = ADDR_W'(1);
                                n_out_valid = 1'b1;
                                n_out_kind  = scf_pkg::OK_SEND;
                                n_out_data  = tx_first;
                                n_out_last  = !frame_done;
                            end
                            if (rx_in_range) begin
                                n_rx_idx = r_rx_idx + IDX_W'(1);
                            end
                            if (frame_done) begin
                                fix_one = 1'b1;
                                n_k     = '0;
                                n_state = scf_pkg::ENG_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            scf_pkg::ENG_RUN: begin
                // command byte first, then receive bytes 2..count+1
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = scf_pkg::OK_QUEUE;
                    n_out_data  = (r_k == '0) ? r_cmd : r_rx_store[run_addr];
                    n_out_last  = (r_k == r_rx_cnt);
                    if (r_k == r_rx_cnt) begin
                        n_state = scf_pkg::ENG_IDLE;
                    end else begin
                        n_k = r_k + ADDR_W'(1);
                    end
                end
            end
            default: n_state = scf_pkg::ENG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scf_pkg::ENG_IDLE;
            r_k         <= '0;
            r_rx_idx    <= '0;
            r_rx_cnt    <= '0;
            r_tx_idx    <= '0;
            r_tx_cnt    <= '0;
            r_cmd       <= '0;
            r_out_valid <= 1'b0;
            r_out_kind  <= scf_pkg::OK_SEND;
            r_out_data  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rx_idx    <= n_rx_idx;
            r_rx_cnt    <= n_rx_cnt;
            r_tx_idx    <= n_tx_idx;
            r_tx_cnt    <= n_tx_cnt;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
            r_out_kind  <= n_out_kind;
            r_out_data  <= n_out_data;
            r_out_last  <= n_out_last;
        end
    end

    // buffers reset to zero; completion rewrites entry 1 after the data write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_rx_store[i] <= '0;
                r_tx_store[i] <= '0;
            end
        end else begin
            if (rx_wr_en) begin
                r_rx_store[r_rx_idx[ADDR_W-1:0]] <= i_evt.data;
            end
            if (fix_one) begin
                r_rx_store[1] <= r_rx_store[0];
            end
            if (copy_en) begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (ADDR_W'(i) < rd_len) begin
                        r_tx_store[i] <= r_rx_store[i + 1];
                    end
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

// File: rtl/i2c_slave_command_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_slave_command_framer: slave-side I2C command framer
// Input stream: one word per bus event. tuser = event (0 address match,
//   1 byte received, 2 transmit byte requested, 3 ignored), tdata = byte.
// Output stream: tuser = kind (0 byte to send, 1 transmit finished,
//   2 frame byte to queue), tdata = byte, tlast on the final word of an event.
// Byte 0 of a frame is the command, byte 1 the length. A read command
//   (bit 7 set) snapshots receive bytes into the transmit buffer and sends
//   the first at once; a frame completion plays out command plus data.
// With an empty queue and a free output, an event passes through the event
//   queue before its first word is loaded into the output register.
// The engine handles one event per cycle while the output is free; an event
//   that completes a frame holds it while the queue run drains one word per
//   cycle that the receiver accepts. A 4-deep event queue in front keeps
//   accepting input meanwhile; tready drops only when that queue is full.
// Reset (synchronous, active low) clears the queue, both 32-byte buffers,
//   all indexes and the output register.
// A stalled receiver holds the output word; the engine waits, the queue fills.
// ----------------------------------------------------------------------------
module i2c_slave_command_framer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [scf_pkg::BYTE_W-1:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]                 i_s_tuser,   // [1:0] op
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [scf_pkg::BYTE_W-1:0]      o_m_tdata,   // [7:0] data
    output logic [1:0]                      o_m_tuser,   // [1:0] kind
    output logic                            o_m_tlast
);

    logic          evt_valid;
    logic          evt_ready;
    scf_pkg::t_evt evt;

    scf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_evt_valid (evt_valid),
        .i_evt_ready (evt_ready),
        .o_evt       (evt)
    );

    scf_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .o_evt_ready (evt_ready),
        .i_evt       (evt),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
`default_nettype wire

// File: rtl/scf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_checker: port-level checks for the command framer
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module scf_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_s_tvalid,
    input wire logic                       o_s_tready,
    input wire logic [scf_pkg::BYTE_W-1:0] i_s_tdata,
    input wire logic [1:0]                 i_s_tuser,
    input wire logic                       o_m_tvalid,
    input wire logic                       i_m_tready,
    input wire logic [scf_pkg::BYTE_W-1:0] o_m_tdata,
    input wire logic [1:0]                 o_m_tuser,
    input wire logic                       o_m_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // transmit-finished is always a single zero word closing its event
    a_done_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == scf_pkg::OK_DONE |-> o_m_tdata == '0 && o_m_tlast)
        else $error("malformed transmit-finished word");

    // the unused kind code never appears
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == scf_pkg::OK_SEND ||
                        o_m_tuser == scf_pkg::OK_DONE ||
                        o_m_tuser == scf_pkg::OK_QUEUE))
        else $error("invalid output kind");

    // nothing is shown in the first cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind i2c_slave_command_framer scf_checker u_scf_checker (.*);
`default_nettype wire

// File: bench/scf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scf_scoreboard: scoreboard for the I2C slave command framer
// Watches both stream channels. Every accepted input word runs through a local
// copy of the framer state (receive and transmit buffers, indexes, command
// byte); the words it must produce are queued and each output word is checked
// field by field against the oldest one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module scf_scoreboard
    import scf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [BYTE_W-1:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]        i_s_tuser,   // [1:0] op
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [BYTE_W-1:0] i_m_tdata,   // [7:0] data
    input  wire logic [1:0]        i_m_tuser,   // [1:0] kind
    input  wire logic              i_m_tlast,
    output int                     o_errors,
    output int                     o_due
);

    typedef struct packed {
        t_out_kind         kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_reply;

    t_reply replies_due[$];

    logic [BYTE_W-1:0] rx_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] tx_mem [BUF_DEPTH];
    logic [IDX_W-1:0]  rx_idx;
    logic [7:0]        rx_cnt;
    logic [5:0]        tx_idx;
    logic [5:0]        tx_cnt;
    logic [BYTE_W-1:0] cmd;

    function automatic t_reply mk_reply(input t_out_kind k, input logic [BYTE_W-1:0] d);
        t_reply r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        return r;
    endfunction

    // advance the framer state by one event and queue the words it emits
    task automatic frame_event(input t_op op, input logic [BYTE_W-1:0] b);
        t_reply run[$];
        int     len;
        int     k;
        case (op)
            OP_ADDR: begin
                rx_idx = '0;
            end
            OP_TX: begin
                if (tx_idx < tx_cnt) begin
                    run.push_back(mk_reply(OK_SEND, tx_mem[tx_idx]));
                    tx_idx = tx_idx + 1'b1;
                end else begin
                    run.push_back(mk_reply(OK_DONE, 8'h00));
                end
            end
            OP_RX: begin
                if (rx_idx == 0) begin
                    cmd = b;
                end else if (rx_idx == 1) begin
                    if (cmd[READ_BIT]) begin
                        // snapshot sees byte 1 from before this length byte lands
                        len = (b > BUF_DEPTH - 1) ? BUF_DEPTH - 1 : int'(b);
                        rx_cnt = '0;
                        for (k = 0; k < len; k++)
                            tx_mem[k] = rx_mem[k + 1];
                        tx_cnt = 6'(len);
                        run.push_back(mk_reply(OK_SEND, tx_mem[0]));
                        tx_idx = 6'd1;
                    end else begin
                        rx_cnt = (b > BUF_DEPTH - 2) ? 8'(BUF_DEPTH - 2) : b;
                    end
                end
                // saturated index: byte dropped, no completion possible
                if (rx_idx < BUF_DEPTH) begin
                    rx_mem[rx_idx] = b;
                    rx_idx = rx_idx + 1'b1;
                    if (int'(rx_cnt) + 2 == int'(rx_idx)) begin
                        rx_mem[1] = rx_mem[0];
                        run.push_back(mk_reply(OK_QUEUE, cmd));
                        for (k = 0; k < rx_cnt; k++)
                            run.push_back(mk_reply(OK_QUEUE, rx_mem[k + 2]));
                    end
                end
            end
            default: ;
        endcase
        for (k = 0; k < run.size(); k++) begin
            if (k == run.size() - 1)
                run[k].last = 1'b1;
            replies_due.push_back(run[k]);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_reply w;
        if (!i_rst_n) begin
            for (int i = 0; i < BUF_DEPTH; i++) begin
                rx_mem[i] = '0;
                tx_mem[i] = '0;
            end
            rx_idx   = '0;
            rx_cnt   = '0;
            tx_idx   = '0;
            tx_cnt   = '0;
            cmd      = '0;
            o_errors = 0;
            replies_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected word, got kind %0d data %02h last %0b",
                             $time, i_m_tuser, i_m_tdata, i_m_tlast);
                    o_errors++;
                end else begin
                    w = replies_due.pop_front();
                    if (w.kind != i_m_tuser) begin
                        $display("%0t: kind mismatch, expected %0d, got %0d",
                                 $time, w.kind, i_m_tuser);
                        o_errors++;
                    end
                    if (w.data != i_m_tdata) begin
                        $display("%0t: data mismatch, expected %02h, got %02h",
                                 $time, w.data, i_m_tdata);
                        o_errors++;
                    end
                    if (w.last != i_m_tlast) begin
                        $display("%0t: tlast mismatch, expected %0b, got %0b",
                                 $time, w.last, i_m_tlast);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                frame_event(t_op'(i_s_tuser), i_s_tdata);
        end
        o_due = replies_due.size();
    end

endmodule

// File: bench/tb_i2c_slave_command_framer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_slave_command_framer: testbench top for the I2C slave command framer
// Drives bus events (directed corner frames, then random write, read, broken
// and noise sequences) through four phases of sender idling and receiver
// stalls. The scf_scoreboard instance predicts and checks every output word.
// ----------------------------------------------------------------------------
module tb_i2c_slave_command_framer;
    import scf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 50;
    localparam int PHASE_ITEMS = 50;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [BYTE_W-1:0] i_s_tdata  = '0;
    logic [1:0]        i_s_tuser  = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [BYTE_W-1:0] o_m_tdata;
    logic [1:0]        o_m_tuser;
    logic              o_m_tlast;

    int errors;
    int words_due;
    int items_sent = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    i2c_slave_command_framer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    scf_scoreboard u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .i_m_tlast  (o_m_tlast),
        .o_errors   (errors),
        .o_due      (words_due)
    );

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(input t_op op, input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // hold off the sender until every predicted word has come out
    task automatic drain;
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (words_due != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(30, 255) : $urandom_range(0, 6);
    endfunction

    task automatic run_random(input int n_items);
        int stop_at;
        int pick;
        int len;
        int nb;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // write frame; trailing bytes test post-completion drop and saturation
                len = pick_len();
                nb = (len > BUF_DEPTH - 2) ? BUF_DEPTH - 2 : len;
                if (len >= BUF_DEPTH - 2 || $urandom_range(0, 9) == 0)
                    nb += $urandom_range(1, 4);
                send_word(OP_ADDR, 8'($urandom));
                send_word(OP_RX, {1'b0, 7'($urandom)});
                send_word(OP_RX, 8'(len));
                repeat (nb) send_word(OP_RX, 8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    send_word(OP_TX, 8'($urandom));
            end else if (pick < 75) begin
                // read frame followed by transmit requests, sometimes past the end
                len = pick_len();
                nb = ((len > BUF_DEPTH - 1) ? BUF_DEPTH - 1 : len) + 2;
                send_word(OP_ADDR, 8'($urandom));
                send_word(OP_RX, {1'b1, 7'($urandom)});
                send_word(OP_RX, 8'(len));
                repeat ($urandom_range(0, nb)) send_word(OP_TX, 8'($urandom));
            end else if (pick < 85) begin
                // broken frame: cut short after the address or the command
                send_word(OP_ADDR, 8'($urandom));
                repeat ($urandom_range(0, 1)) send_word(OP_RX, 8'($urandom));
            end else begin
                send_word(t_op'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, no idling
        send_word(OP_NONE, 8'hC3);
        send_word(OP_TX, 8'h00);              // nothing loaded: transmit finished
        send_word(OP_ADDR, 8'h00);
        send_word(OP_RX, 8'h00);              // write, zero length
        send_word(OP_RX, 8'h00);
        send_word(OP_ADDR, 8'hFF);
        send_word(OP_RX, 8'h7F);
        send_word(OP_RX, 8'h03);
        send_word(OP_RX, 8'hFF);
        send_word(OP_RX, 8'h00);
        send_word(OP_RX, 8'hA5);
        send_word(OP_ADDR, 8'h00);
        send_word(OP_RX, 8'h80);              // read two bytes
        send_word(OP_RX, 8'h02);
        send_word(OP_TX, 8'hFF);
        send_word(OP_TX, 8'h00);
        send_word(OP_TX, 8'h5A);
        send_word(OP_ADDR, 8'h00);
        send_word(OP_RX, 8'hFF);              // read, zero length still sends a byte
        send_word(OP_RX, 8'h00);
        send_word(OP_TX, 8'h00);
        send_word(OP_ADDR, 8'h00);
        send_word(OP_RX, 8'h81);              // read length clamps
        send_word(OP_RX, 8'hFF);
        send_word(OP_TX, 8'h00);
        send_word(OP_TX, 8'h00);

        run_random(PHASE_ITEMS);
        drain();

        idle_pct  = 67;
        stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain();

        idle_pct  = 0;
        stall_pct = 67;
        run_random(PHASE_ITEMS);
        drain();

        idle_pct  = 20;
        stall_pct = 20;
        run_random(PHASE_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
